// ===== rtl/b64e_pkg.sv =====
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the alphabet lookup for the Base64 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

  // position of the next byte within its 3-byte group
  typedef enum logic [1:0] {
    PH0 = 2'd0,
    PH1 = 2'd1,
    PH2 = 2'd2,
    PH3 = 2'd3
  } phase_t;

  // ascii codes that do not come from a plain offset
  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_UPPER = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_LOWER = 8'h47;  // 'a' minus 26
  localparam logic [7:0] DIGIT_OFS  = 8'd4;   // 52 minus '0'

  // depth of the queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  // up to four characters caused by one input word
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;  // index of the final character
    logic            eom;       // final character closes the message
  } bundle_t;

  // sextet to ascii character
  function automatic logic [7:0] b64_sym(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] r;
    w = {2'b00, v};
    if (v < 6'd26) begin
      r = CHAR_UPPER + w;
    end else if (v < 6'd52) begin
      r = CHAR_LOWER + w;
    end else if (v < 6'd62) begin
      r = w - DIGIT_OFS;
    end else if (v == 6'd62) begin
      r = CHAR_PLUS;
    end else begin
      r = CHAR_SLASH;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/b64e_front.sv =====
// ----------------------------------------------------------------------------
// b64e_front
// Tracks the group phase and carried bits, and turns each input word into a
// bundle of one to four characters.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic [7:0]       data_byte,
  input  wire logic             end_of_message,
  output b64e_pkg::bundle_t     bundle
);

  b64e_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]       carry_r, carry_nxt;

  // phase and carried bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= b64e_pkg::PH0;
      carry_r <= 4'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

  // next phase
  always_comb begin
    phase_nxt = b64e_pkg::PH0;
    carry_nxt = 4'd0;
    unique case (phase_r)
      b64e_pkg::PH1: begin
        if (!end_of_message) begin
          phase_nxt = b64e_pkg::PH2;
          carry_nxt = data_byte[3:0];
        end
      end
      b64e_pkg::PH2: begin
        phase_nxt = b64e_pkg::PH0;
      end
      default: begin
        if (!end_of_message) begin
          phase_nxt = b64e_pkg::PH1;
          carry_nxt = {2'b00, data_byte[1:0]};
        end
      end
    endcase
  end

  // characters for this word
  always_comb begin
    bundle          = '0;
    bundle.eom      = end_of_message;
    unique case (phase_r)
      b64e_pkg::PH1: begin
        bundle.chars[0] = b64e_pkg::b64_sym({carry_r[1:0], data_byte[7:4]});
        if (end_of_message) begin
          bundle.chars[1] = b64e_pkg::b64_sym({data_byte[3:0], 2'b00});
          bundle.chars[2] = b64e_pkg::CHAR_PAD;
          bundle.last_idx = 2'd2;
        end
      end
      b64e_pkg::PH2: begin
        bundle.chars[0] = b64e_pkg::b64_sym({carry_r, data_byte[7:6]});
        bundle.chars[1] = b64e_pkg::b64_sym(data_byte[5:0]);
        bundle.last_idx = 2'd1;
      end
      default: begin
        bundle.chars[0] = b64e_pkg::b64_sym(data_byte[7:2]);
        if (end_of_message) begin
          bundle.chars[1] = b64e_pkg::b64_sym({data_byte[1:0], 4'b0000});
          bundle.chars[2] = b64e_pkg::CHAR_PAD;
          bundle.chars[3] = b64e_pkg::CHAR_PAD;
          bundle.last_idx = 2'd3;
        end
      end
    endcase
  end

  // the unused phase code is never entered
  a_phase_used: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != b64e_pkg::PH3)
    else $error("front entered unused phase");

  // a group that reaches its third byte always closes there
  a_phase2_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase_r == b64e_pkg::PH2) |=> phase_r == b64e_pkg::PH0)
    else $error("phase did not wrap after third byte");

endmodule

`default_nettype wire

// ===== rtl/b64e_fifo.sv =====
// ----------------------------------------------------------------------------
// b64e_fifo
// Short queue of character bundles between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire b64e_pkg::bundle_t wr_data,
  output logic                   full,
  input  wire logic              pop,
  output b64e_pkg::bundle_t      rd_data,
  output logic                   empty
);

  b64e_pkg::bundle_t                 mem_r [b64e_pkg::QDEPTH];
  logic [b64e_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [b64e_pkg::QCNT_W-1:0]       count_r;
  logic                              do_push, do_pop;

  assign full    = (count_r == b64e_pkg::QCNT_W'(b64e_pkg::QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // fill count stays within the depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= b64e_pkg::QCNT_W'(b64e_pkg::QDEPTH))
    else $error("queue count out of range");

  // a lone push grows the count by one
  a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not follow push");

  // pointers agree with the fill count
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == b64e_pkg::QCNT_W'(b64e_pkg::QDEPTH))
      |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== rtl/b64e_back.sv =====
// ----------------------------------------------------------------------------
// b64e_back
// Holds one bundle in its output register and hands out its characters one
// word per cycle while pop is high, loading the next bundle without a gap.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire b64e_pkg::bundle_t q_data,
  input  wire logic              q_empty,
  output logic                   q_pop,
  input  wire logic              pop,
  output logic                   empty,
  output logic [7:0]             out_char,
  output logic                   out_last
);

  b64e_pkg::bundle_t bnd_r;
  logic              valid_r, valid_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic              is_final, take, load;

  assign is_final = (idx_r == bnd_r.last_idx);
  assign take     = pop && valid_r;
  assign load     = !q_empty && (!valid_r || (take && is_final));
  assign q_pop    = load;

  // next index and valid
  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = 2'd0;
      valid_nxt = 1'b1;
    end else if (take) begin
      if (is_final) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // bundle register
  always_ff @(posedge clk) begin
    if (load) begin
      bnd_r <= q_data;
    end
  end

  // result ports
  assign empty    = !valid_r;
  assign out_char = bnd_r.chars[idx_r];
  assign out_last = bnd_r.eom && is_final;

  // index never runs past the bundle's final character
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> idx_r <= bnd_r.last_idx)
    else $error("character index past bundle end");

  // an untaken word holds its place
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !pop) |=> valid_r && idx_r == $past(idx_r))
    else $error("waiting word moved without pop");

endmodule

`default_nettype wire

// ===== rtl/base64_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming Base64 encoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: a byte word is taken at a clock edge
//   with push high and full low. in_end_of_message marks the last byte of a
//   message; every message has at least one byte.
//   Result side is a queue read port: while empty is low, out_char holds the
//   oldest waiting character; pop high takes it at the clock edge.
//   out_last is high on the final character of each encoded message.
//   Each byte yields one to four characters (four when a message ends on the
//   first byte of a group, counting padding).
//   The first character of a byte passes through the queue and then the
//   output register before it is shown, when nothing is ahead of it.
//   Throughput: one character per cycle while pop stays high, set by the
//   single output register; a long message yields four characters per
//   three bytes, plus padding. A two-bundle queue lets input lead output.
//   Reset (rst_n low, synchronous) empties the queue and output register and
//   returns to the start of a group. While the receiver holds off pop, the
//   queue fills and full rises; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_end_of_message,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_char,
  output logic            out_last
);

  b64e_pkg::bundle_t front_bundle;
  b64e_pkg::bundle_t q_data;
  logic              accept;
  logic              q_empty;
  logic              q_pop;

  assign accept = push && !full;

  // phase tracking and character generation
  b64e_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .data_byte      (in_data_byte),
    .end_of_message (in_end_of_message),
    .bundle         (front_bundle)
  );

  // bundle queue
  b64e_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (front_bundle),
    .full    (full),
    .pop     (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // character output
  b64e_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (q_data),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_char (out_char),
    .out_last (out_last)
  );

endmodule

`default_nettype wire
